### rtl/core/mpm_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot membership package
// Shared constants, types and saturation helpers for the membership pipeline.
// ----------------------------------------------------------------------------
package mpm_pkg;

   localparam int SCREEN_WIDTH   = 128;
   localparam int SCREEN_HEIGHT  = 64;
   localparam int MAX_ITERATIONS = 20;
   localparam int FRAC_BITS      = 15;

   localparam int PX_W    = 7;
   localparam int PY_W    = 6;
   localparam int VAL_W   = 32;
   localparam int SHIFT_W = 4;
   localparam int SUM_W   = 51;

   // Escape bound 2.0 in 16.15 format.
   localparam logic signed [VAL_W-1:0] ESCAPE_LIMIT = 32'sd2 <<< FRAC_BITS;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_CENTER_RE  = 2'd0,
      REG_CENTER_IM  = 2'd1,
      REG_SCALE_SHIFT = 2'd2
   } csr_index_type;

   // Data handed from one iteration cell to the next.
   typedef struct packed {
      logic                    escaped;
      logic signed [VAL_W-1:0] z_re;
      logic signed [VAL_W-1:0] z_im;
      logic signed [VAL_W-1:0] c_re;
      logic signed [VAL_W-1:0] c_im;
   } cell_data_type;

   // Saturate a wide signed sum to the 32-bit signed range.
   function automatic logic signed [VAL_W-1:0] sat_wide(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] max_v;
      logic signed [SUM_W-1:0] min_v;
      max_v = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
      min_v = {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
      if (v > max_v) begin
         sat_wide = {1'b0, {(VAL_W-1){1'b1}}};
      end else if (v < min_v) begin
         sat_wide = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         sat_wide = v[VAL_W-1:0];
      end
   endfunction

endpackage

### rtl/core/mpm_map.sv
// ----------------------------------------------------------------------------
// Pixel mapping stage
// Maps a pixel position to the complex point c and seeds z with zero.
// ----------------------------------------------------------------------------
module mpm_map
   import mpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic [PX_W-1:0]          pixel_x,
   input  logic [PY_W-1:0]          pixel_y,
   input  logic signed [VAL_W-1:0]  center_re,
   input  logic signed [VAL_W-1:0]  center_im,
   input  logic [SHIFT_W-1:0]       scale_shift,
   output logic                     out_valid,
   output cell_data_type            out_data
);

   localparam int OFF_W = VAL_W + 1;

   logic signed [PX_W:0]      dx;
   logic signed [PY_W:0]      dy;
   logic [SHIFT_W-1:0]        shamt;
   logic signed [OFF_W-1:0]   off_x;
   logic signed [OFF_W-1:0]   off_y;
   logic signed [OFF_W-1:0]   sum_x;
   logic signed [OFF_W-1:0]   sum_y;
   logic                      valid_ff;
   cell_data_type             data_ff;
   cell_data_type             data_in;

   // Signed pixel offsets from the screen center, scaled to 15 fraction bits.
   always_comb begin
      dx    = $signed({1'b0, pixel_x}) - $signed((PX_W+1)'(SCREEN_WIDTH / 2));
      dy    = $signed({1'b0, pixel_y}) - $signed((PY_W+1)'(SCREEN_HEIGHT / 2));
      shamt = SHIFT_W'(FRAC_BITS) - scale_shift;
      off_x = $signed({{(OFF_W-PX_W-1){dx[PX_W]}}, dx}) <<< shamt;
      off_y = $signed({{(OFF_W-PY_W-1){dy[PY_W]}}, dy}) <<< shamt;
      sum_x = off_x + $signed({center_re[VAL_W-1], center_re});
      sum_y = off_y + $signed({center_im[VAL_W-1], center_im});
      data_in.escaped = 1'b0;
      data_in.z_re    = '0;
      data_in.z_im    = '0;
      data_in.c_re    = sat_wide($signed({{(SUM_W-OFF_W){sum_x[OFF_W-1]}}, sum_x}));
      data_in.c_im    = sat_wide($signed({{(SUM_W-OFF_W){sum_y[OFF_W-1]}}, sum_y}));
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/core/mpm_cell.sv
// ----------------------------------------------------------------------------
// Iteration cell
// One step z = z^2 + c in two stages: products, then sums with saturation.
// ----------------------------------------------------------------------------
module mpm_cell
   import mpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  cell_data_type in_data,
   output logic          out_valid,
   output cell_data_type out_data
);

   localparam int PROD_W = 2 * VAL_W;

   logic                     mul_valid_ff;
   logic signed [PROD_W-1:0] rr_ff;
   logic signed [PROD_W-1:0] ii_ff;
   logic signed [PROD_W-1:0] ri_ff;
   cell_data_type            mul_data_ff;
   logic                     add_valid_ff;
   cell_data_type            add_data_ff;
   cell_data_type            add_data_in;
   logic signed [SUM_W-1:0]  re_sum;
   logic signed [SUM_W-1:0]  im_sum;
   logic                     esc_now;

   // Valid bits of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         add_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= in_valid;
         add_valid_ff <= mul_valid_ff;
      end
   end

   // Product stage.
   always_ff @(posedge clock) begin
      if (advance) begin
         rr_ff       <= in_data.z_re * in_data.z_re;
         ii_ff       <= in_data.z_im * in_data.z_im;
         ri_ff       <= in_data.z_re * in_data.z_im;
         mul_data_ff <= in_data;
      end
   end

   // Sum stage: floor to 15 fraction bits, add c, saturate and test the bound.
   // The cross term is doubled by shifting one place less.
   always_comb begin
      re_sum = $signed(SUM_W'(rr_ff >>> FRAC_BITS)) - $signed(SUM_W'(ii_ff >>> FRAC_BITS))
             + $signed({{(SUM_W-VAL_W){mul_data_ff.c_re[VAL_W-1]}}, mul_data_ff.c_re});
      im_sum = $signed(SUM_W'(ri_ff >>> (FRAC_BITS - 1)))
             + $signed({{(SUM_W-VAL_W){mul_data_ff.c_im[VAL_W-1]}}, mul_data_ff.c_im});
      add_data_in      = mul_data_ff;
      add_data_in.z_re = sat_wide(re_sum);
      add_data_in.z_im = sat_wide(im_sum);
      esc_now = (add_data_in.z_re > ESCAPE_LIMIT) || (add_data_in.z_re < -ESCAPE_LIMIT) ||
                (add_data_in.z_im > ESCAPE_LIMIT) || (add_data_in.z_im < -ESCAPE_LIMIT);
      add_data_in.escaped = mul_data_ff.escaped | esc_now;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         add_data_ff <= add_data_in;
      end
   end

   assign out_valid = add_valid_ff;
   assign out_data  = add_data_ff;

endmodule

### rtl/core/mandelbrot_point_membership_unit.sv
// ----------------------------------------------------------------------------
// Mandelbrot point membership unit
// Tests whether a display pixel lies in the Mandelbrot set (fixed point).
// ----------------------------------------------------------------------------
// Usage:
// A transaction on the req_ channel carries one pixel position. One
// transaction on the rsp_ channel returns in_set for it, in request order.
// The datapath is a chain of 20 identical iteration cells behind a mapping
// stage; each cell has a product stage and a sum stage, and a result
// passes the mapping register and then the product and sum registers of
// every cell in turn. The chain accepts one request per cycle while it
// moves, so sustained throughput is one item per cycle.
// The last cell's register is the output register. When the receiver stalls
// with a result pending, the whole chain holds and req_ready drops.
// The csr_ channel is always ready; writes should be made while idle.
// Reset clears all valid bits and sets center to 0 and scale_shift to 5.
// ----------------------------------------------------------------------------
module mandelbrot_point_membership_unit
   import mpm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PX_W-1:0]         req_pixel_x,
   input  logic [PY_W-1:0]         req_pixel_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_in_set,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [VAL_W-1:0]        csr_data
);

   logic signed [VAL_W-1:0] center_re_ff;
   logic signed [VAL_W-1:0] center_im_ff;
   logic [SHIFT_W-1:0]      scale_shift_ff;
   logic                    advance;
   logic                    chain_valid [MAX_ITERATIONS+1];
   cell_data_type           chain_data  [MAX_ITERATIONS+1];

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_re_ff   <= '0;
         center_im_ff   <= '0;
         scale_shift_ff <= SHIFT_W'(5);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CENTER_RE:   center_re_ff   <= csr_data;
            REG_CENTER_IM:   center_im_ff   <= csr_data;
            REG_SCALE_SHIFT: scale_shift_ff <= csr_data[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // The chain moves unless a finished result waits on a stalled receiver.
   assign advance   = !chain_valid[MAX_ITERATIONS] || rsp_ready;
   assign req_ready = advance;

   mpm_map u_map (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .pixel_x     (req_pixel_x),
      .pixel_y     (req_pixel_y),
      .center_re   (center_re_ff),
      .center_im   (center_im_ff),
      .scale_shift (scale_shift_ff),
      .out_valid   (chain_valid[0]),
      .out_data    (chain_data[0])
   );

   // One cell per iteration.
   for (genvar i = 0; i < MAX_ITERATIONS; i++) begin : g_cell
      mpm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   assign rsp_valid  = chain_valid[MAX_ITERATIONS];
   assign rsp_in_set = !chain_data[MAX_ITERATIONS].escaped;

endmodule

### rtl/core/mpm_checker.sv
// ----------------------------------------------------------------------------
// Membership unit port checker
// Concurrent checks on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
module mpm_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_in_set,
   input logic csr_ready
);

   // A pending result is held until its transaction completes.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_in_set))
      else $error("result dropped or changed while stalled");

   // No result right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Requests are refused exactly when a result is stalled.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output stall");

   // Configuration is always accepted.
   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

endmodule

bind mandelbrot_point_membership_unit mpm_checker u_mpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_in_set (rsp_in_set),
   .csr_ready  (csr_ready)
);
